>>> hw/rtl/rfa_pkg.sv
// Shared types, codes and constants of the rational fraction ALU.
`default_nettype none

package rfa_pkg;

	localparam int unsigned FIELD_W   = 32;
	localparam int unsigned DEN_W     = 31;
	localparam int unsigned ACTION_W  = 4;
	localparam int unsigned ERR_W     = 2;
	localparam int unsigned WIDTH_DEF = 32;

	localparam logic [ACTION_W-1:0] ACT_NORM    = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD     = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_SUB     = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_MUL     = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_DIV     = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_SQUARE  = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_RECIP   = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_NEGATE  = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_EQUAL   = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_GREATER = 4'd9;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic signed [FIELD_W-1:0] a_num;
		logic signed [FIELD_W-1:0] a_den;
		logic signed [FIELD_W-1:0] b_num;
		logic signed [FIELD_W-1:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] res_num;
		logic [DEN_W-1:0]          res_den;
		logic                      compare_flag;
		logic [ERR_W-1:0]          error_code;
	} out_item_t;

	// per-cycle operation broadcast along the cell row
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SHR_ALL,
		OP_SHR_X,
		OP_SHR_Y,
		OP_STEP,
		OP_DIVP,
		OP_DIVQ
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     ge;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/rfa_cell.sv
// One bit slice of the reducer row: x, y, p, q bits plus two borrow chains.
`default_nettype none

module rfa_cell (
	input  wire logic              clk,
	input  wire rfa_pkg::cell_ctl_t ctl,
	input  wire logic              ld_a,
	input  wire logic              ld_b,
	input  wire logic              x_hi,
	input  wire logic              y_hi,
	input  wire logic              p_hi,
	input  wire logic              q_hi,
	input  wire logic              x_lo,
	input  wire logic              p_lo,
	input  wire logic              q_lo,
	input  wire logic              b1_in,
	input  wire logic              b2_in,
	output logic                   x,
	output logic                   y,
	output logic                   p,
	output logic                   q,
	output logic                   b1_out,
	output logic                   b2_out
);
	import rfa_pkg::*;

	logic x_q, y_q, p_q, q_q;
	logic a1, d1, d2;

	// chain 1: x - y (or shifted x - y while dividing); chain 2: y - x
	assign a1     = (ctl.op inside {OP_DIVP, OP_DIVQ}) ? x_lo : x_q;
	assign d1     = a1 ^ y_q ^ b1_in;
	assign b1_out = (~a1 & y_q) | (~(a1 ^ y_q) & b1_in);
	assign d2     = y_q ^ x_q ^ b2_in;
	assign b2_out = (~y_q & x_q) | (~(y_q ^ x_q) & b2_in);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				x_q <= ld_a;
				p_q <= ld_a;
				y_q <= ld_b;
				q_q <= ld_b;
			end
			OP_SHR_ALL: begin
				x_q <= x_hi;
				y_q <= y_hi;
				p_q <= p_hi;
				q_q <= q_hi;
			end
			OP_SHR_X: x_q <= x_hi;
			OP_SHR_Y: y_q <= y_hi;
			OP_STEP: begin
				if (ctl.ge) begin
					x_q <= d1;
				end else begin
					y_q <= d2;
				end
			end
			OP_DIVP: begin
				x_q <= ctl.ge ? d1 : x_lo;
				p_q <= p_lo;
			end
			OP_DIVQ: begin
				x_q <= ctl.ge ? d1 : x_lo;
				q_q <= q_lo;
			end
			default: begin
			end
		endcase
	end

	assign x = x_q;
	assign y = y_q;
	assign p = p_q;
	assign q = q_q;

endmodule

`default_nettype wire

>>> hw/rtl/rfa_reducer.sv
// Fraction reducer: binary GCD and exact restoring division on a row of bit cells.
`default_nettype none

module rfa_reducer #(
	parameter int unsigned N = 2 * rfa_pkg::WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [N-1:0] n_in,
	input  wire logic [N-1:0] d_in,
	output logic              done,
	output logic [N-1:0]      quo_n,
	output logic [N-1:0]      quo_d
);
	import rfa_pkg::*;

	localparam int unsigned CNT_W = $clog2(N);

	typedef enum logic [2:0] {
		R_IDLE,
		R_TWOS,
		R_STEIN,
		R_DIVP,
		R_DIVQ,
		R_DONE
	} red_state_t;

	red_state_t       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N-1:0]     x_v, y_v, p_v, q_v, b1_v, b2_v;
	logic [N-1:0]     x_hi_v, y_hi_v, p_hi_v, q_hi_v;
	logic [N-1:0]     x_lo_v, p_lo_v, q_lo_v, b1_in_v, b2_in_v;
	cell_op_t         op;
	logic             ge, lo0;
	cell_ctl_t        ctl;

	always_comb begin
		op = OP_HOLD;
		case (state_q)
			R_IDLE:  if (start) op = OP_LOAD;
			R_TWOS:  if (!(x_v[0] | y_v[0])) op = OP_SHR_ALL;
			R_STEIN: begin
				if (x_v != '0) begin
					if (!x_v[0]) begin
						op = OP_SHR_X;
					end else if (!y_v[0]) begin
						op = OP_SHR_Y;
					end else begin
						op = OP_STEP;
					end
				end
			end
			R_DIVP:  op = OP_DIVP;
			R_DIVQ:  op = OP_DIVQ;
			default: op = OP_HOLD;
		endcase
	end

	// while dividing, the bit shifted out of x's top counts toward the compare
	assign ge  = (op inside {OP_DIVP, OP_DIVQ}) ? (x_v[N-1] | ~b1_v[N-1]) : ~b1_v[N-1];
	assign lo0 = (op == OP_DIVQ) ? q_v[N-1] : p_v[N-1];
	assign ctl = '{op: op, ge: ge};

	assign x_hi_v  = {1'b0, x_v[N-1:1]};
	assign y_hi_v  = {1'b0, y_v[N-1:1]};
	assign p_hi_v  = {1'b0, p_v[N-1:1]};
	assign q_hi_v  = {1'b0, q_v[N-1:1]};
	assign x_lo_v  = {x_v[N-2:0], lo0};
	assign p_lo_v  = {p_v[N-2:0], ge};
	assign q_lo_v  = {q_v[N-2:0], ge};
	assign b1_in_v = {b1_v[N-2:0], 1'b0};
	assign b2_in_v = {b2_v[N-2:0], 1'b0};

	for (genvar i = 0; i < N; i++) begin : g_cell
		rfa_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.ld_a   (n_in[i]),
			.ld_b   (d_in[i]),
			.x_hi   (x_hi_v[i]),
			.y_hi   (y_hi_v[i]),
			.p_hi   (p_hi_v[i]),
			.q_hi   (q_hi_v[i]),
			.x_lo   (x_lo_v[i]),
			.p_lo   (p_lo_v[i]),
			.q_lo   (q_lo_v[i]),
			.b1_in  (b1_in_v[i]),
			.b2_in  (b2_in_v[i]),
			.x      (x_v[i]),
			.y      (y_v[i]),
			.p      (p_v[i]),
			.q      (q_v[i]),
			.b1_out (b1_v[i]),
			.b2_out (b2_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				R_IDLE:  if (start) state_q <= R_TWOS;
				R_TWOS:  if (x_v[0] | y_v[0]) state_q <= R_STEIN;
				R_STEIN: begin
					if (x_v == '0) begin
						state_q <= R_DIVP;
						cnt_q   <= '0;
					end
				end
				R_DIVP: begin
					if (cnt_q == CNT_W'(N - 1)) begin
						state_q <= R_DIVQ;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				R_DIVQ: begin
					if (cnt_q == CNT_W'(N - 1)) begin
						state_q <= R_DONE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				R_DONE:  state_q <= R_IDLE;
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done  = (state_q == R_DONE);
	assign quo_n = p_v;
	assign quo_d = q_v;

endmodule

`default_nettype wire

>>> hw/rtl/rational_fraction_alu.sv
// Rational fraction ALU: reduced norm, add, sub, mul, div, square, recip, neg, compare.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one item: an action code and
//    two signed fractions a_num/a_den and b_num/b_den (low WIDTH bits used).
//  - Output channel out_valid/out_ready/out_data returns one item per input item:
//    reduced res_num/res_den, compare_flag and error_code.
//  - One item is worked at a time. in_ready is high only while the sequencer idles.
//  - Each reduction runs on a row of 2*WIDTH bit cells: a common-two strip, a
//    binary GCD and two exact divisions. An item uses up to three reductions
//    (operand a, operand b, result) and three products from one multiplier;
//    unknown actions and zero denominators finish without any reduction.
//  - The result sits in an output register. A new item is accepted while that
//    result waits; a finished item waits in its last state until the register
//    frees up, so a stalled receiver holds the block without loss.
//  - Reset clears the sequencer, the reducer state and out_valid.
`default_nettype none

module rational_fraction_alu #(
	parameter int unsigned WIDTH = rfa_pkg::WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rfa_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rfa_pkg::out_item_t      out_data
);
	import rfa_pkg::*;

	localparam int unsigned P_W = 2 * WIDTH;
	localparam logic [P_W-1:0] HALF = P_W'(1) << (WIDTH - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_RED_A,
		S_PREP_B,
		S_RED_B,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_SUM,
		S_RED_R,
		S_OVF,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [ACTION_W-1:0] action_q;
	logic [WIDTH-1:0]    an_q, ad_q, bn_q, bd_q;
	logic                an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [P_W-1:0]      prod_q, p1_q, p2_q;
	logic [P_W-1:0]      rn_q, rd_q;
	logic                rn_neg_q;
	logic                red_start_q;
	logic [P_W-1:0]      red_n_q, red_d_q;
	logic                red_done;
	logic [P_W-1:0]      red_quo_n, red_quo_d;
	out_item_t           res_q, out_q;
	logic                out_valid_q;

	function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] u);
		return u[WIDTH-1] ? (~u + 1'b1) : u;
	endfunction

	logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
	assign in_an = in_data.a_num[WIDTH-1:0];
	assign in_ad = in_data.a_den[WIDTH-1:0];
	assign in_bn = in_data.b_num[WIDTH-1:0];
	assign in_bd = in_data.b_den[WIDTH-1:0];

	logic uses_b;
	assign uses_b = action_q inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_EQUAL,
		ACT_GREATER};

	// multiplier operand select; identity products keep every action uniform
	logic [WIDTH-1:0] mx, my;
	always_comb begin
		mx = '0;
		my = '0;
		case (state_q)
			S_MUL1: begin
				case (action_q)
					ACT_ADD, ACT_SUB, ACT_DIV, ACT_EQUAL, ACT_GREATER: begin
						mx = an_q; my = bd_q;
					end
					ACT_MUL:    begin mx = an_q; my = bn_q; end
					ACT_SQUARE: begin mx = an_q; my = an_q; end
					ACT_RECIP:  begin mx = ad_q; my = WIDTH'(1); end
					default:    begin mx = an_q; my = WIDTH'(1); end
				endcase
			end
			S_MUL2: begin
				if (action_q inside {ACT_ADD, ACT_SUB, ACT_EQUAL, ACT_GREATER}) begin
					mx = bn_q; my = ad_q;
				end
			end
			S_MUL3: begin
				case (action_q)
					ACT_ADD, ACT_SUB, ACT_MUL: begin mx = ad_q; my = bd_q; end
					ACT_DIV:    begin mx = bn_q; my = ad_q; end
					ACT_SQUARE: begin mx = ad_q; my = ad_q; end
					ACT_RECIP:  begin mx = an_q; my = WIDTH'(1); end
					default:    begin mx = ad_q; my = WIDTH'(1); end
				endcase
			end
			default: begin
			end
		endcase
	end

	// product signs
	logic s1, s2, s3, s1e, s2e;
	always_comb begin
		s1 = 1'b0;
		s2 = 1'b0;
		s3 = 1'b0;
		case (action_q)
			ACT_NORM:   s1 = an_neg_q;
			ACT_ADD, ACT_EQUAL, ACT_GREATER: begin s1 = an_neg_q; s2 = bn_neg_q; end
			ACT_SUB:    begin s1 = an_neg_q; s2 = ~bn_neg_q; end
			ACT_MUL:    s1 = an_neg_q ^ bn_neg_q;
			ACT_DIV:    begin s1 = an_neg_q; s3 = bn_neg_q; end
			ACT_RECIP:  s3 = an_neg_q;
			ACT_NEGATE: s1 = ~an_neg_q;
			default: begin
			end
		endcase
	end
	assign s1e = s1 & (p1_q != '0);
	assign s2e = s2 & (p2_q != '0);

	// signed-magnitude sum and compare of the two cross terms
	logic           same_sign, p1_ge, sum_neg, flag_eq, flag_gt, flag;
	logic [P_W-1:0] sum_mag;
	always_comb begin
		same_sign = (s1e == s2e);
		p1_ge     = (p1_q >= p2_q);
		if (same_sign) begin
			sum_mag = p1_q + p2_q;
			sum_neg = s1e;
		end else if (p1_ge) begin
			sum_mag = p1_q - p2_q;
			sum_neg = s1e;
		end else begin
			sum_mag = p2_q - p1_q;
			sum_neg = s2e;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
		flag_eq = (p1_q == p2_q) && same_sign;
		if (!same_sign) begin
			flag_gt = ~s1e;
		end else if (s1e) begin
			flag_gt = (p1_q < p2_q);
		end else begin
			flag_gt = (p1_q > p2_q);
		end
		flag = (action_q == ACT_EQUAL) ? flag_eq : flag_gt;
	end

	// final range check and two's complement numerator
	logic                     ovf;
	logic [P_W-1:0]           rn_tc;
	logic signed [WIDTH-1:0]  num_low;
	assign ovf     = (rd_q >= HALF) || (rn_neg_q ? (rn_q > HALF) : (rn_q >= HALF));
	assign rn_tc   = rn_neg_q ? (~rn_q + 1'b1) : rn_q;
	assign num_low = rn_tc[WIDTH-1:0];

	// reducer kick: operand a, operand b, or the final fraction
	logic red_go;
	always_comb begin
		red_go = 1'b0;
		case (state_q)
			S_CHECK:  red_go = (action_q <= ACT_GREATER) && (ad_q != '0) &&
				!(uses_b && bd_q == '0) && (an_q != '0);
			S_PREP_B: red_go = uses_b && (bn_q != '0);
			S_SUM:    red_go = !(action_q inside {ACT_EQUAL, ACT_GREATER}) &&
				(prod_q != '0) && (sum_mag != '0);
			default:  red_go = 1'b0;
		endcase
	end

	rfa_reducer #(
		.N (P_W)
	) u_reducer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start_q),
		.n_in   (red_n_q),
		.d_in   (red_d_q),
		.done   (red_done),
		.quo_n  (red_quo_n),
		.quo_d  (red_quo_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			red_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			red_start_q <= red_go;
			if (state_q == S_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						action_q <= in_data.action;
						an_q     <= mag_of(in_an);
						ad_q     <= mag_of(in_ad);
						bn_q     <= mag_of(in_bn);
						bd_q     <= mag_of(in_bd);
						an_neg_q <= in_an[WIDTH-1];
						ad_neg_q <= in_ad[WIDTH-1];
						bn_neg_q <= in_bn[WIDTH-1];
						bd_neg_q <= in_bd[WIDTH-1];
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (action_q > ACT_GREATER) begin
						res_q   <= '{res_num: '0, res_den: DEN_W'(1), compare_flag: 1'b0,
							error_code: ERR_NONE};
						state_q <= S_FINISH;
					end else if (ad_q == '0 || (uses_b && bd_q == '0)) begin
						res_q   <= '{res_num: '0, res_den: '0, compare_flag: 1'b0,
							error_code: ERR_ZERO_DEN};
						state_q <= S_FINISH;
					end else if (an_q != '0) begin
						red_n_q     <= P_W'(an_q);
						red_d_q     <= P_W'(ad_q);
						state_q     <= S_RED_A;
					end else begin
						an_neg_q <= 1'b0;
						state_q  <= S_PREP_B;
					end
				end
				S_RED_A: begin
					if (red_done) begin
						an_q     <= red_quo_n[WIDTH-1:0];
						ad_q     <= red_quo_d[WIDTH-1:0];
						an_neg_q <= an_neg_q ^ ad_neg_q;
						state_q  <= S_PREP_B;
					end
				end
				S_PREP_B: begin
					if (!uses_b) begin
						state_q <= S_MUL1;
					end else if (bn_q != '0) begin
						red_n_q     <= P_W'(bn_q);
						red_d_q     <= P_W'(bd_q);
						state_q     <= S_RED_B;
					end else begin
						bn_neg_q <= 1'b0;
						state_q  <= S_MUL1;
					end
				end
				S_RED_B: begin
					if (red_done) begin
						bn_q     <= red_quo_n[WIDTH-1:0];
						bd_q     <= red_quo_d[WIDTH-1:0];
						bn_neg_q <= bn_neg_q ^ bd_neg_q;
						state_q  <= S_MUL1;
					end
				end
				S_MUL1: begin
					prod_q  <= P_W'(mx) * P_W'(my);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p1_q    <= prod_q;
					prod_q  <= P_W'(mx) * P_W'(my);
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					p2_q    <= prod_q;
					prod_q  <= P_W'(mx) * P_W'(my);
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (action_q == ACT_EQUAL || action_q == ACT_GREATER) begin
						res_q   <= '{res_num: '0, res_den: DEN_W'(1), compare_flag: flag,
							error_code: ERR_NONE};
						state_q <= S_FINISH;
					end else if (prod_q == '0) begin
						// division by a zero fraction
						res_q   <= '{res_num: '0, res_den: '0, compare_flag: 1'b0,
							error_code: ERR_ZERO_DEN};
						state_q <= S_FINISH;
					end else if (sum_mag == '0) begin
						// zero numerator keeps its denominator unreduced
						rn_q     <= '0;
						rn_neg_q <= 1'b0;
						rd_q     <= prod_q;
						state_q  <= S_OVF;
					end else begin
						red_n_q     <= sum_mag;
						red_d_q     <= prod_q;
						rn_neg_q    <= sum_neg ^ s3;
						state_q     <= S_RED_R;
					end
				end
				S_RED_R: begin
					if (red_done) begin
						rn_q    <= red_quo_n;
						rd_q    <= red_quo_d;
						state_q <= S_OVF;
					end
				end
				S_OVF: begin
					if (ovf) begin
						res_q <= '{res_num: '0, res_den: '0, compare_flag: 1'b0,
							error_code: ERR_OVERFLOW};
					end else begin
						res_q <= '{res_num: FIELD_W'(num_low),
							res_den: DEN_W'(rd_q[WIDTH-2:0]), compare_flag: 1'b0,
							error_code: ERR_NONE};
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
